// ===== hw/rtl/ifft2d_pkg.sv =====
// ----------------------------------------------------------------------------
// ifft2d_pkg
// shared sizes, sequencer states and the constant twiddle tables of the
// two-dimensional inverse fft core
// ----------------------------------------------------------------------------
package ifft2d_pkg;

	localparam int ROWS_LOG2    = 6;
	localparam int COLS_LOG2    = 6;
	localparam int TW_BITS      = 18;
	localparam int TW_FRAC      = TW_BITS - 2;
	localparam int MAX_LOG2     = (ROWS_LOG2 > COLS_LOG2) ? ROWS_LOG2 : COLS_LOG2;
	localparam int TW_COUNT     = 1 << (MAX_LOG2 - 1);
	localparam int TW_IDX_W     = (MAX_LOG2 > 1) ? MAX_LOG2 - 1 : 1;
	localparam int ADDR_W       = ROWS_LOG2 + COLS_LOG2;
	localparam int STORE_SIZE   = 1 << ADDR_W;
	localparam int POS_W        = MAX_LOG2;
	localparam int STG_W        = $clog2(MAX_LOG2 + 1);
	localparam int DATA_W       = 32;
	localparam int SCALE_W      = 16;
	localparam int INDEX_W      = 12;
	localparam int SAMPLE_W     = 16;
	localparam int MODE_W       = 2;

	localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RUN  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_MUL,
		ST_RD_OUT,
		ST_SW_RDP,
		ST_SW_RDQ,
		ST_SW_WRP,
		ST_SW_WRQ,
		ST_BF_RDA,
		ST_BF_RDB,
		ST_BF_MUL,
		ST_BF_ADD,
		ST_BF_WRA,
		ST_BF_WRB,
		ST_ACK
	} state_t;

	typedef logic [TW_COUNT-1:0][TW_BITS-1:0] tw_tab_t;

	function automatic longint round_sh(input longint x, input int s);
		longint h;
		longint neg;
		h   = longint'(1) <<< (s - 1);
		neg = (x < 0) ? 64'sd1 : 64'sd0;
		return (x + h - neg) >>> s;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] bitv;
		v    = v_in;
		r    = '0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v = v - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic tw_tab_t build_tw(input bit want_sin);
		longint  rc [MAX_LOG2 + 2];
		longint  rs [MAX_LOG2 + 2];
		longint  q30;
		longint  cr;
		longint  ci;
		longint  nr;
		longint  ni;
		longint  wr;
		longint  wi;
		logic [63:0] c;
		tw_tab_t tab;
		q30 = longint'(1) <<< 30;
		for (int m = 0; m < MAX_LOG2 + 2; m++) begin
			rc[m] = 0;
			rs[m] = 0;
		end
		rc[1] = -q30;
		rs[1] = 0;
		rc[2] = 0;
		rs[2] = q30;
		for (int m = 3; m <= MAX_LOG2; m++) begin
			c     = isqrt64(64'(q30 + rc[m-1]) << 29);
			rc[m] = longint'(c);
			rs[m] = longint'(udiv64(64'(rs[m-1]) << 29, c));
		end
		for (int k = 0; k < TW_COUNT; k++) begin
			cr = q30;
			ci = 0;
			for (int b = 0; b + 1 < MAX_LOG2; b++) begin
				if (((k >> b) & 1) != 0) begin
					wr = rc[MAX_LOG2 - b];
					wi = rs[MAX_LOG2 - b];
					nr = round_sh(cr * wr - ci * wi, 30);
					ni = round_sh(cr * wi + ci * wr, 30);
					cr = nr;
					ci = ni;
				end
			end
			if (want_sin)
				tab[k] = TW_BITS'(round_sh(ci, 30 - TW_FRAC));
			else
				tab[k] = TW_BITS'(round_sh(cr, 30 - TW_FRAC));
		end
		return tab;
	endfunction

	localparam tw_tab_t TW_COS = build_tw(1'b0);
	localparam tw_tab_t TW_SIN = build_tw(1'b1);

endpackage

// ===== hw/rtl/ifft2d_bfly.sv =====
// ----------------------------------------------------------------------------
// ifft2d_bfly
// radix-2 butterfly datapath: registered complex product b*w, rounded,
// then saturated sum and difference against a
// ----------------------------------------------------------------------------
module ifft2d_bfly
	import ifft2d_pkg::*;
(
	input  logic                      clk,
	input  logic                      mul_en,
	input  logic                      add_en,
	input  logic signed [DATA_W-1:0]  a_re,
	input  logic signed [DATA_W-1:0]  a_im,
	input  logic signed [DATA_W-1:0]  b_re,
	input  logic signed [DATA_W-1:0]  b_im,
	input  logic signed [TW_BITS-1:0] w_re,
	input  logic signed [TW_BITS-1:0] w_im,
	output logic signed [DATA_W-1:0]  sum_re,
	output logic signed [DATA_W-1:0]  sum_im,
	output logic signed [DATA_W-1:0]  dif_re,
	output logic signed [DATA_W-1:0]  dif_im
);

	localparam int PROD_W = DATA_W + TW_BITS;
	localparam int ACC_W  = PROD_W + 1;
	localparam int T_W    = ACC_W - TW_FRAC;
	localparam int R_W    = T_W + 1;

	logic signed [PROD_W-1:0] rr_s1, ii_s1, ri_s1, ir_s1;
	logic signed [ACC_W-1:0]  acc_re, acc_im;
	logic signed [ACC_W-1:0]  rnd_re, rnd_im;
	logic signed [T_W-1:0]    t_re_s2, t_im_s2;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			rr_s1 <= b_re * w_re;
			ii_s1 <= b_im * w_im;
			ri_s1 <= b_re * w_im;
			ir_s1 <= b_im * w_re;
		end
	end

	// half away from zero
	always_comb begin
		acc_re = ACC_W'(rr_s1) - ACC_W'(ii_s1);
		acc_im = ACC_W'(ri_s1) + ACC_W'(ir_s1);
		rnd_re = (acc_re + (ACC_W'(1) <<< (TW_FRAC - 1)) - ACC_W'(acc_re < 0)) >>> TW_FRAC;
		rnd_im = (acc_im + (ACC_W'(1) <<< (TW_FRAC - 1)) - ACC_W'(acc_im < 0)) >>> TW_FRAC;
	end

	always_ff @(posedge clk) begin
		if (add_en) begin
			t_re_s2 <= T_W'(rnd_re);
			t_im_s2 <= T_W'(rnd_im);
		end
	end

	function automatic logic signed [DATA_W-1:0] sat(input logic signed [R_W-1:0] x);
		logic signed [R_W-1:0] hi;
		logic signed [R_W-1:0] lo;
		hi = R_W'({1'b0, {(DATA_W-1){1'b1}}});
		lo = -hi - R_W'(1);
		if (x > hi)
			return {1'b0, {(DATA_W-1){1'b1}}};
		else if (x < lo)
			return {1'b1, {(DATA_W-1){1'b0}}};
		else
			return x[DATA_W-1:0];
	endfunction

	assign sum_re = sat(R_W'(a_re) + R_W'(t_re_s2));
	assign sum_im = sat(R_W'(a_im) + R_W'(t_im_s2));
	assign dif_re = sat(R_W'(a_re) - R_W'(t_re_s2));
	assign dif_im = sat(R_W'(a_im) - R_W'(t_im_s2));

endmodule

// ===== hw/rtl/inverse_fft_2d_core.sv =====
// ----------------------------------------------------------------------------
// inverse_fft_2d_core
// in-place row-column radix-2 inverse fft over a complex matrix held in one
// synchronous sample memory
// ----------------------------------------------------------------------------
// input words arrive on s_axis (tuser = mode); mode 0 writes one complex
// sample at a column-major index, mode 1 runs the transform, mode 2 reads
// the scaled real part of one entry, mode 3 is dropped.
// results leave on m_axis: a read gives the sample and its index, a
// finished transform gives one word with tuser set.
// a load is written as it is accepted; a read passes the memory read
// register, then the scaling product register, then the output register.
// the transform works per row then per column: a bit-reverse pass that
// swaps each entry pair with its reversed index, then every butterfly of
// every stage, all through the one sample memory.
// s_axis_tready is high only while idle; a stalled m_axis holds the last
// step of the word until the output register frees.
// reset clears the sequencer, output valid and output_scale (to 1024);
// the sample memory is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module inverse_fft_2d_core
	import ifft2d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // index[11:0], real_in[27:12], imag_in[43:28]
	input  logic [1:0]  s_axis_tuser,   // mode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // sample_real[15:0], sample_index[27:16]
	output logic        m_axis_tuser    // is_done_ack
);

	localparam int PRD_W = DATA_W + SCALE_W + 1;
	localparam int RND_W = PRD_W - SCALE_W;

	state_t state_q, state_nxt;

	logic [SCALE_W-1:0]     scale_q;
	logic [15:0]            bfly_cnt_q;
	logic                   col_phase_q;
	logic [POS_W-1:0]       line_q;
	logic [POS_W-1:0]       i_q;
	logic [POS_W-1:0]       bi_q;
	logic [STG_W-1:0]       stg_q;
	logic [INDEX_W-1:0]     rd_index_q;
	logic signed [PRD_W-1:0] rd_prod_s1;
	logic [2*DATA_W-1:0]    a_q;
	logic [2*DATA_W-1:0]    rdata_q;

	logic [2*DATA_W-1:0]    mem [STORE_SIZE];
	logic                   wr_en;
	logic [ADDR_W-1:0]      waddr, raddr;
	logic [2*DATA_W-1:0]    wdata;

	logic                   in_acc, out_free, out_load, out_ack;
	logic [INDEX_W-1:0]     in_index;
	logic [SAMPLE_W-1:0]    in_re, in_im;
	logic [MODE_W-1:0]      in_mode;

	logic                   m_valid_q, m_ack_q;
	logic [SAMPLE_W-1:0]    m_real_q;
	logic [INDEX_W-1:0]     m_index_q;
	logic [SAMPLE_W-1:0]    rd_sat;

	logic [STG_W-1:0]       lg;
	logic [POS_W-1:0]       n_mask, last_bi, half, kk, pa, pb, rev_i, p_line, lines_last;
	logic [ADDR_W-1:0]      addr_a, addr_b, addr_i, addr_j;
	logic [TW_IDX_W-1:0]    tw_idx;
	logic                   swap_need, last_i, last_bf, last_stg, last_line;

	logic signed [DATA_W-1:0] sum_re, sum_im, dif_re, dif_im;
	logic                   mul_en, add_en;
	logic                   adv_i, adv_bf;

	assign in_mode  = s_axis_tuser;
	assign in_index = s_axis_tdata[11:0];
	assign in_re    = s_axis_tdata[27:12];
	assign in_im    = s_axis_tdata[43:28];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	// line geometry
	always_comb begin
		lg         = col_phase_q ? STG_W'(ROWS_LOG2) : STG_W'(COLS_LOG2);
		n_mask     = POS_W'((1 << lg) - 1);
		last_bi    = POS_W'((1 << (lg - STG_W'(1))) - 1);
		lines_last = col_phase_q ? POS_W'((1 << COLS_LOG2) - 1) : POS_W'((1 << ROWS_LOG2) - 1);
		half       = POS_W'(1) << (stg_q - STG_W'(1));
		kk         = bi_q & (half - POS_W'(1));
		pa         = ((bi_q >> (stg_q - STG_W'(1))) << stg_q) | kk;
		pb         = pa | half;
		p_line     = kk << (STG_W'(MAX_LOG2) - stg_q);
		tw_idx     = p_line[TW_IDX_W-1:0];
		for (int b = 0; b < POS_W; b++)
			rev_i[b] = i_q[POS_W-1-b];
		rev_i      = rev_i >> (STG_W'(MAX_LOG2) - lg);
		swap_need  = rev_i > i_q;
		last_i     = i_q == n_mask;
		last_bf    = bi_q == last_bi;
		last_stg   = stg_q == lg;
		last_line  = line_q == lines_last;
	end

	function automatic logic [ADDR_W-1:0] line_addr(input logic colp, input logic [POS_W-1:0] ln,
		input logic [POS_W-1:0] pos);
		if (colp)
			return (ADDR_W'(ln) << ROWS_LOG2) | ADDR_W'(pos);
		else
			return (ADDR_W'(pos) << ROWS_LOG2) | ADDR_W'(ln);
	endfunction

	assign addr_a = line_addr(col_phase_q, line_q, pa);
	assign addr_b = line_addr(col_phase_q, line_q, pb);
	assign addr_i = line_addr(col_phase_q, line_q, i_q);
	assign addr_j = line_addr(col_phase_q, line_q, rev_i);

	ifft2d_bfly u_bfly (
		.clk    (clk),
		.mul_en (mul_en),
		.add_en (add_en),
		.a_re   (a_q[DATA_W-1:0]),
		.a_im   (a_q[2*DATA_W-1:DATA_W]),
		.b_re   (rdata_q[DATA_W-1:0]),
		.b_im   (rdata_q[2*DATA_W-1:DATA_W]),
		.w_re   (TW_COS[tw_idx]),
		.w_im   (TW_SIN[tw_idx]),
		.sum_re (sum_re),
		.sum_im (sum_im),
		.dif_re (dif_re),
		.dif_im (dif_im)
	);

	// read scaling, half away from zero, saturate
	always_comb begin
		logic signed [RND_W-1:0] r;
		r = RND_W'((rd_prod_s1 + (PRD_W'(1) <<< (SCALE_W - 1)) - PRD_W'(rd_prod_s1 < 0))
			>>> SCALE_W);
		if (r > RND_W'(32767))
			rd_sat = 16'h7fff;
		else if (r < -RND_W'(32768))
			rd_sat = 16'h8000;
		else
			rd_sat = r[SAMPLE_W-1:0];
	end

	always_comb begin
		state_nxt = state_q;
		wr_en     = 1'b0;
		waddr     = addr_i;
		wdata     = rdata_q;
		raddr     = addr_i;
		mul_en    = 1'b0;
		add_en    = 1'b0;
		out_load  = 1'b0;
		out_ack   = 1'b0;
		adv_i     = 1'b0;
		adv_bf    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				raddr = ADDR_W'(in_index);
				waddr = ADDR_W'(in_index);
				wdata = {{(DATA_W-SAMPLE_W){in_im[SAMPLE_W-1]}}, in_im,
					{(DATA_W-SAMPLE_W){in_re[SAMPLE_W-1]}}, in_re};
				if (in_acc) begin
					case (in_mode)
						MODE_LOAD: wr_en = 1'b1;
						MODE_RUN:  state_nxt = ST_SW_RDP;
						MODE_READ: state_nxt = ST_RD_MUL;
						default:   state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_RD_MUL: state_nxt = ST_RD_OUT;
			ST_RD_OUT: begin
				if (out_free) begin
					out_load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_SW_RDP: begin
				raddr = addr_i;
				if (swap_need) begin
					state_nxt = ST_SW_RDQ;
				end else begin
					adv_i     = 1'b1;
					state_nxt = last_i ? ST_BF_RDA : ST_SW_RDP;
				end
			end
			ST_SW_RDQ: begin
				raddr     = addr_j;
				state_nxt = ST_SW_WRP;
			end
			ST_SW_WRP: begin
				wr_en     = 1'b1;
				waddr     = addr_i;
				wdata     = rdata_q;
				state_nxt = ST_SW_WRQ;
			end
			ST_SW_WRQ: begin
				wr_en     = 1'b1;
				waddr     = addr_j;
				wdata     = a_q;
				adv_i     = 1'b1;
				state_nxt = last_i ? ST_BF_RDA : ST_SW_RDP;
			end
			ST_BF_RDA: begin
				raddr     = addr_a;
				state_nxt = ST_BF_RDB;
			end
			ST_BF_RDB: begin
				raddr     = addr_b;
				state_nxt = ST_BF_MUL;
			end
			ST_BF_MUL: begin
				mul_en    = 1'b1;
				state_nxt = ST_BF_ADD;
			end
			ST_BF_ADD: begin
				add_en    = 1'b1;
				state_nxt = ST_BF_WRA;
			end
			ST_BF_WRA: begin
				wr_en     = 1'b1;
				waddr     = addr_a;
				wdata     = {sum_im, sum_re};
				state_nxt = ST_BF_WRB;
			end
			ST_BF_WRB: begin
				wr_en  = 1'b1;
				waddr  = addr_b;
				wdata  = {dif_im, dif_re};
				adv_bf = 1'b1;
				if (!last_bf || !last_stg)
					state_nxt = ST_BF_RDA;
				else if (!last_line || !col_phase_q)
					state_nxt = ST_SW_RDP;
				else
					state_nxt = ST_ACK;
			end
			ST_ACK: begin
				if (out_free) begin
					out_load  = 1'b1;
					out_ack   = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// sample memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_phase_q <= 1'b0;
			line_q      <= '0;
			i_q         <= '0;
			bi_q        <= '0;
			stg_q       <= STG_W'(1);
			bfly_cnt_q  <= '0;
		end else begin
			if (state_q == ST_IDLE && in_acc && in_mode == MODE_RUN) begin
				col_phase_q <= 1'b0;
				line_q      <= '0;
				i_q         <= '0;
				bi_q        <= '0;
				stg_q       <= STG_W'(1);
			end
			if (adv_i)
				i_q <= last_i ? '0 : i_q + POS_W'(1);
			if (adv_bf) begin
				bfly_cnt_q <= bfly_cnt_q + 16'd1;
				if (!last_bf) begin
					bi_q <= bi_q + POS_W'(1);
				end else begin
					bi_q <= '0;
					if (!last_stg) begin
						stg_q <= stg_q + STG_W'(1);
					end else begin
						stg_q <= STG_W'(1);
						i_q   <= '0;
						if (!last_line) begin
							line_q <= line_q + POS_W'(1);
						end else begin
							line_q      <= '0;
							col_phase_q <= ~col_phase_q;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			scale_q <= SCALE_W'(1024);
		else if (cfg_wr_en)
			scale_q <= cfg_wr_data;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc)
			rd_index_q <= in_index;
		if (state_q == ST_RD_MUL)
			rd_prod_s1 <= PRD_W'($signed(rdata_q[DATA_W-1:0])) * PRD_W'($signed({1'b0, scale_q}));
		if (state_q == ST_SW_RDQ || state_q == ST_BF_RDB)
			a_q <= rdata_q;
	end

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (out_load)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_ack_q   <= out_ack;
			m_real_q  <= out_ack ? '0 : rd_sat;
			m_index_q <= out_ack ? '0 : rd_index_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'b0, m_index_q, m_real_q};
	assign m_axis_tuser  = m_ack_q;

endmodule
